FILE: hdl/rrtt_pkg.sv
// shared constants for the round robin task table: command codes and field widths
// no dependencies
package rrtt_pkg;

	localparam int CTX_W  = 32;
	localparam int SLOT_W = 8;
	localparam int CNT_W  = 9;
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TERM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SCHED = 2'd2;

endpackage

FILE: hdl/round_robin_task_table.sv
// round robin task table top level: command sequencer around the context memory
// depends on rrtt_pkg and rrtt_ram
//
// The table holds up to MAX_TASKS 32-bit context pointers packed from slot 0 up,
// in one memory with a single write and a single read port. Add, a failed command,
// terminate of the last slot, a schedule on an empty table and an unused command
// code are answered straight from idle with a registered result word. Terminate
// of a lower slot s with n tasks moves the later entries down one a cycle through
// the read then write ports. Schedule saves any running context, wraps the advanced
// slot into range in k = floor((cur + 1) / n) subtract steps (0 on the first
// schedule), reads the new slot and presents its context; k is at most MAX_TASKS
// after terminates have shrunk the table, and usually 0 or 1. One command is in
// flight at a time; a new word is taken only once the previous result has left or
// leaves in the same cycle.
module round_robin_task_table #(
	parameter int MAX_TASKS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rrtt_pkg::CMD_W-1:0] cmd,
	input  logic [rrtt_pkg::CTX_W-1:0] context_req,
	input  logic [rrtt_pkg::SLOT_W-1:0] slot,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       ok,
	output logic [rrtt_pkg::CTX_W-1:0] next_context,
	output logic [rrtt_pkg::SLOT_W-1:0] assigned_slot,
	output logic [rrtt_pkg::CNT_W-1:0] task_count
);

	import rrtt_pkg::*;

	localparam int IW   = $clog2(MAX_TASKS);
	localparam int CW   = $clog2(MAX_TASKS + 1);
	localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_MOD   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] cur_q, cur_d;
	logic          started_q, started_d;
	logic [CW-1:0] cand_q, cand_d;
	logic [IW-1:0] ptr_q, ptr_d;
	logic [IW-1:0] last_q, last_d;

	logic             pend_ok_q, pend_ok_d;
	logic [CTX_W-1:0] pend_next_q, pend_next_d;
	logic [CNT_W-1:0] pend_cnt_q, pend_cnt_d;

	logic              out_valid_q;
	logic              ok_q;
	logic [CTX_W-1:0]  next_q;
	logic [SLOT_W-1:0] assigned_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_free;
	logic              in_acc;
	logic              imm_load;
	logic              imm_ok;
	logic [CTX_W-1:0]  imm_next;
	logic [SLOT_W-1:0] imm_assigned;
	logic [CNT_W-1:0]  imm_cnt;

	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	logic [CTX_W-1:0] wr_data;
	logic [IW-1:0]    rd_addr;
	logic [CTX_W-1:0] rd_data;

	logic [CMPW-1:0] slot_x;
	logic [CMPW-1:0] cnt_x;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign slot_x   = CMPW'(slot);
	assign cnt_x    = CMPW'(count_q);

	// context memory
	rrtt_ram #(
		.WIDTH(CTX_W),
		.DEPTH(MAX_TASKS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// command sequencer
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		cur_d        = cur_q;
		started_d    = started_q;
		cand_d       = cand_q;
		ptr_d        = ptr_q;
		last_d       = last_q;
		pend_ok_d    = pend_ok_q;
		pend_next_d  = pend_next_q;
		pend_cnt_d   = pend_cnt_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = context_req;
		rd_addr      = '0;
		imm_load     = 1'b0;
		imm_ok       = 1'b0;
		imm_next     = '0;
		imm_assigned = '0;
		imm_cnt      = CNT_W'(count_q);

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd)
						CMD_ADD: begin
							imm_load = 1'b1;
							if (count_q < CW'(MAX_TASKS)) begin
								wr_en        = 1'b1;
								wr_addr      = IW'(count_q);
								imm_ok       = 1'b1;
								imm_assigned = SLOT_W'(count_q);
								count_d      = count_q + CW'(1);
								imm_cnt      = CNT_W'(count_q + CW'(1));
							end
						end
						CMD_TERM: begin
							if (slot_x < cnt_x) begin
								count_d = count_q - CW'(1);
								if (slot_x == cnt_x - CMPW'(1)) begin
									// last slot: nothing to move
									imm_load = 1'b1;
									imm_ok   = 1'b1;
									imm_cnt  = CNT_W'(count_q - CW'(1));
								end else begin
									rd_addr    = IW'(slot_x + CMPW'(1));
									ptr_d      = IW'(slot_x + CMPW'(1));
									last_d     = IW'(count_q - CW'(1));
									pend_ok_d  = 1'b1;
									pend_next_d = '0;
									pend_cnt_d = CNT_W'(count_q - CW'(1));
									state_d    = ST_SHIFT;
								end
							end else begin
								imm_load = 1'b1;
							end
						end
						CMD_SCHED: begin
							if (count_q == '0) begin
								imm_load = 1'b1;
								imm_ok   = 1'b1;
								imm_next = context_req;
							end else begin
								// save the running context, then advance
								if (started_q) begin
									wr_en   = 1'b1;
									wr_addr = cur_q;
									cand_d  = CW'(cur_q) + CW'(1);
								end else begin
									cand_d  = '0;
								end
								started_d  = 1'b1;
								pend_ok_d  = 1'b1;
								pend_cnt_d = CNT_W'(count_q);
								state_d    = ST_MOD;
							end
						end
						default: begin
							imm_load = 1'b1;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				// move one entry down per cycle
				wr_en   = 1'b1;
				wr_addr = ptr_q - IW'(1);
				wr_data = rd_data;
				if (ptr_q == last_q) begin
					state_d = ST_DONE;
				end else begin
					rd_addr = ptr_q + IW'(1);
					ptr_d   = ptr_q + IW'(1);
				end
			end
			ST_MOD: begin
				// wrap the advanced slot by repeated subtraction
				if (cand_q >= count_q) begin
					cand_d = cand_q - count_q;
				end else begin
					rd_addr = IW'(cand_q);
					cur_d   = IW'(cand_q);
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				pend_next_d = rd_data;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			cur_q     <= cur_d;
			started_q <= started_d;
			if (imm_load || (state_q == ST_DONE && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		cand_q      <= cand_d;
		ptr_q       <= ptr_d;
		last_q      <= last_d;
		pend_ok_q   <= pend_ok_d;
		pend_next_q <= pend_next_d;
		pend_cnt_q  <= pend_cnt_d;
		if (imm_load) begin
			ok_q       <= imm_ok;
			next_q     <= imm_next;
			assigned_q <= imm_assigned;
			cnt_q      <= imm_cnt;
		end else if (state_q == ST_DONE && out_free) begin
			ok_q       <= pend_ok_q;
			next_q     <= pend_next_q;
			assigned_q <= '0;
			cnt_q      <= pend_cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign next_context  = next_q;
	assign assigned_slot = assigned_q;
	assign task_count    = cnt_q;

endmodule

FILE: hdl/rrtt_ram.sv
// generic simple dual port ram: one write port, one read port with registered read data
// no dependencies
module rrtt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
